// File: rtl/rgb_to_hsl_converter_core_macros.svh
// ----------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Shared concurrent assertion forms used by the converter modules.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define RTHC_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define RTHC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RTHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RTHC_ASSERT(label, clk, rst, expr, msg)
`define RTHC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RTHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/rthc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Beat types, hue sector codes and fixed-point constants of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rthc_pkg;

  localparam int CH_W    = 8;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 8;
  localparam int LIGHT_W = 9;

  // Hue is in 1/64 degree: one sixth of the circle is 3840.
  localparam logic [HUE_W-1:0] HUE_SECTOR     = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL       = 15'd23040;
  localparam logic [SAT_W-1:0] SAT_MAX        = 8'd255;

  // Reciprocal division: recip(x) = floor(2^RECIP_SHIFT / x).
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam int NUM_HUE_W   = 20;
  localparam int NUM_SAT_W   = 16;
  localparam int QH_W        = 12;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   saturation;
    logic [LIGHT_W-1:0] lightness;
    logic [CH_W-1:0]    alpha_out;
  } hsl_t;

  // Classified pixel handed from the front end to the divide pipeline.
  typedef struct packed {
    sector_t            sector;
    logic               neg;
    logic [CH_W-1:0]    mag;
    logic [CH_W-1:0]    chroma;
    logic [CH_W-1:0]    denom;
    logic [LIGHT_W-1:0] sum;
    logic [CH_W-1:0]    alpha;
  } cls_t;

endpackage

`default_nettype wire

// File: rtl/rthc_front.sv
// ----------------------------------------------------------------------------
// RGB to HSL front end
// Finds max and min channel, the hue sector, chroma and saturation divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rthc_front (
  input  rthc_pkg::pixel_t pixel,
  output rthc_pkg::cls_t   cls
);
  import rthc_pkg::*;

  logic [CH_W-1:0]    mx;
  logic [CH_W-1:0]    mn;
  logic [CH_W-1:0]    pa;
  logic [CH_W-1:0]    pb;
  logic [LIGHT_W-1:0] sum;
  sector_t            sector;

  // Pick the largest channel, ties going to red, then green.
  always_comb begin
    if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
      sector = SEC_RED;
      mx     = pixel.red;
      pa     = pixel.green;
      pb     = pixel.blue;
    end else if (pixel.green >= pixel.blue) begin
      sector = SEC_GREEN;
      mx     = pixel.green;
      pa     = pixel.blue;
      pb     = pixel.red;
    end else begin
      sector = SEC_BLUE;
      mx     = pixel.blue;
      pa     = pixel.red;
      pb     = pixel.green;
    end
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
  end

  assign sum = LIGHT_W'(mx) + LIGHT_W'(mn);

  // The hue numerator is kept as sign and magnitude.
  always_comb begin
    cls.sector = sector;
    cls.neg    = (pa < pb);
    cls.mag    = (pa < pb) ? (pb - pa) : (pa - pb);
    cls.chroma = mx - mn;
    cls.sum    = sum;
    cls.alpha  = pixel.alpha_in;
    // The divisor folds around the middle of the lightness range.
    if (sum <= LIGHT_W'(SAT_MAX)) begin
      cls.denom = sum[CH_W-1:0];
    end else begin
      cls.denom = CH_W'(LIGHT_W'(2 * SAT_MAX) - sum);
    end
  end

endmodule

`default_nettype wire

// File: rtl/rthc_fifo.sv
// ----------------------------------------------------------------------------
// RGB to HSL classify queue
// Short queue between front end and divide pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsl_converter_core_macros.svh"

module rthc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rthc_pkg::cls_t din,
  output logic           full,
  input  logic           pop,
  output rthc_pkg::cls_t dout,
  output logic           empty
);
  import rthc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t          entry [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = entry[rptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  `RTHC_ASSERT(a_count_range, clk, rst, count <= CW'(DEPTH), "queue count over depth")
  `RTHC_ASSERT_NEXT(a_count_up, clk, rst, wr && !rd, count == $past(count) + CW'(1), "missed write")
  `RTHC_ASSERT_NEXT(a_count_down, clk, rst, rd && !wr, count == $past(count) - CW'(1), "missed read")

endmodule

`default_nettype wire

// File: rtl/rthc_back.sv
// ----------------------------------------------------------------------------
// RGB to HSL divide pipeline
// Reciprocal-multiply divides for hue and saturation, then the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsl_converter_core_macros.svh"

module rthc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cls_valid,
  input  rthc_pkg::cls_t cls,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output rthc_pkg::hsl_t result
);
  import rthc_pkg::*;

  localparam int PH_W = NUM_HUE_W + RECIP_W;
  localparam int PS_W = NUM_SAT_W + RECIP_W;

  logic [RECIP_W-1:0] recip_tab [256];

  // Reciprocal table, worked out at elaboration. Entry zero is unused.
  for (genvar i = 0; i < 256; i++) begin : g_recip
    localparam int unsigned RV = (1 << RECIP_SHIFT) / ((i == 0) ? 1 : i);
    assign recip_tab[i] = (i == 0) ? '0 : RECIP_W'(RV);
  end

  logic adv;

  // Stage 1: numerators and reciprocals.
  logic                 v1;
  sector_t              s1_sector;
  logic                 s1_neg;
  logic [CH_W-1:0]      s1_c;
  logic [CH_W-1:0]      s1_d;
  logic [LIGHT_W-1:0]   s1_sum;
  logic [CH_W-1:0]      s1_alpha;
  logic [NUM_HUE_W-1:0] s1_nh;
  logic [NUM_SAT_W-1:0] s1_ns;
  logic [RECIP_W-1:0]   s1_rh;
  logic [RECIP_W-1:0]   s1_rs;

  // Stage 2: estimated quotients.
  logic                 v2;
  sector_t              s2_sector;
  logic                 s2_neg;
  logic [CH_W-1:0]      s2_c;
  logic [CH_W-1:0]      s2_d;
  logic [LIGHT_W-1:0]   s2_sum;
  logic [CH_W-1:0]      s2_alpha;
  logic [NUM_HUE_W-1:0] s2_nh;
  logic [NUM_SAT_W-1:0] s2_ns;
  logic [QH_W-1:0]      s2_qh;
  logic [SAT_W-1:0]     s2_qs;
  logic [PH_W-1:0]      ph;
  logic [PS_W-1:0]      ps;

  // Stage 3: quotient times divisor.
  logic                 v3;
  sector_t              s3_sector;
  logic                 s3_neg;
  logic [CH_W-1:0]      s3_c;
  logic [CH_W-1:0]      s3_d;
  logic [LIGHT_W-1:0]   s3_sum;
  logic [CH_W-1:0]      s3_alpha;
  logic [NUM_HUE_W-1:0] s3_nh;
  logic [NUM_SAT_W-1:0] s3_ns;
  logic [QH_W-1:0]      s3_qh;
  logic [SAT_W-1:0]     s3_qs;
  logic [NUM_HUE_W-1:0] s3_mh;
  logic [NUM_SAT_W-1:0] s3_ms;

  // Stage 4 correction.
  logic [NUM_HUE_W-1:0] remh;
  logic [NUM_SAT_W-1:0] rems;
  logic [QH_W-1:0]      qh;
  logic [SAT_W:0]       qs;
  logic [HUE_W-1:0]     hue_val;
  logic [SAT_W-1:0]     sat_val;
  logic                 grey;

  // The whole pipeline moves unless the result beat is held.
  assign adv = !(result_valid && result_stall);
  assign pop = adv && cls_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= cls_valid;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  // Rounding numerators: floor((2N + x) / 2x) equals floor(N' / x), N' = N + floor(x / 2).
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sector <= cls.sector;
      s1_neg    <= cls.neg;
      s1_c      <= cls.chroma;
      s1_d      <= cls.denom;
      s1_sum    <= cls.sum;
      s1_alpha  <= cls.alpha;
      s1_nh     <= NUM_HUE_W'(cls.mag) * NUM_HUE_W'(HUE_SECTOR)
                 + NUM_HUE_W'(cls.chroma[CH_W-1:1]);
      s1_ns     <= NUM_SAT_W'(cls.chroma) * NUM_SAT_W'(SAT_MAX)
                 + NUM_SAT_W'(cls.denom[CH_W-1:1]);
      s1_rh     <= recip_tab[cls.chroma];
      s1_rs     <= recip_tab[cls.denom];
    end
  end

  assign ph = PH_W'(s1_nh) * PH_W'(s1_rh);
  assign ps = PS_W'(s1_ns) * PS_W'(s1_rs);

  // The estimate is the true quotient or one below it.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sector <= s1_sector;
      s2_neg    <= s1_neg;
      s2_c      <= s1_c;
      s2_d      <= s1_d;
      s2_sum    <= s1_sum;
      s2_alpha  <= s1_alpha;
      s2_nh     <= s1_nh;
      s2_ns     <= s1_ns;
      s2_qh     <= ph[RECIP_SHIFT +: QH_W];
      s2_qs     <= ps[RECIP_SHIFT +: SAT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sector <= s2_sector;
      s3_neg    <= s2_neg;
      s3_c      <= s2_c;
      s3_d      <= s2_d;
      s3_sum    <= s2_sum;
      s3_alpha  <= s2_alpha;
      s3_nh     <= s2_nh;
      s3_ns     <= s2_ns;
      s3_qh     <= s2_qh;
      s3_qs     <= s2_qs;
      s3_mh     <= NUM_HUE_W'(s2_qh) * NUM_HUE_W'(s2_c);
      s3_ms     <= NUM_SAT_W'(s2_qs) * NUM_SAT_W'(s2_d);
    end
  end

  // One compare and step fixes the quotient estimates.
  assign remh = s3_nh - s3_mh;
  assign rems = s3_ns - s3_ms;
  assign qh   = s3_qh + QH_W'(remh >= NUM_HUE_W'(s3_c));
  assign qs   = (SAT_W + 1)'(s3_qs) + (SAT_W + 1)'(rems >= NUM_SAT_W'(s3_d));
  assign grey = (s3_c == '0);

  // Place the offset in its sector; a negative red hue wraps around.
  always_comb begin
    case (s3_sector)
      SEC_RED: begin
        if (s3_neg && qh != '0) begin
          hue_val = HUE_FULL - HUE_W'(qh);
        end else if (s3_neg) begin
          hue_val = '0;
        end else begin
          hue_val = HUE_W'(qh);
        end
      end
      SEC_GREEN: begin
        hue_val = s3_neg ? HUE_GREEN_BASE - HUE_W'(qh) : HUE_GREEN_BASE + HUE_W'(qh);
      end
      SEC_BLUE: begin
        hue_val = s3_neg ? HUE_BLUE_BASE - HUE_W'(qh) : HUE_BLUE_BASE + HUE_W'(qh);
      end
      default: begin
        hue_val = '0;
      end
    endcase
    sat_val = (qs > (SAT_W + 1)'(SAT_MAX)) ? SAT_MAX : qs[SAT_W-1:0];
    if (grey) begin
      hue_val = '0;
      sat_val = '0;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (adv) begin
      result.hue        <= hue_val;
      result.saturation <= sat_val;
      result.lightness  <= s3_sum;
      result.alpha_out  <= s3_alpha;
    end
  end

  `RTHC_ASSERT_IMPL(a_hue_rem, clk, rst, v3 && !grey, remh < (NUM_HUE_W'(s3_c) << 1), "hue quotient estimate off by more than one")
  `RTHC_ASSERT_IMPL(a_sat_rem, clk, rst, v3 && !grey, rems < (NUM_SAT_W'(s3_d) << 1), "saturation quotient estimate off by more than one")
  `RTHC_ASSERT_IMPL(a_hue_range, clk, rst, result_valid, result.hue < HUE_FULL, "hue out of range")

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsl_converter_core.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter core
// Converts 8-bit RGBA pixels to fixed-point hue, saturation and lightness.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and gives one result per clock when
// nothing stalls. The front end classifies each pixel in the cycle it is
// taken and writes it into a queue of QUEUE_DEPTH entries; a four-stage
// divide pipeline (reciprocal lookup, multiply, back-multiply, correction)
// drains that queue and moves as a whole whenever the result register is
// empty or being taken. pixel_stall rises only when the queue is full, which
// happens only after result_stall has held the result beat for a while.
// Hue is in 1/64 degree, saturation is 0 to 255, lightness is max plus min,
// and a grey pixel gives zero hue and zero saturation.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_converter_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  rthc_pkg::pixel_t pixel,
  output logic             result_valid,
  input  logic             result_stall,
  output rthc_pkg::hsl_t   result
);
  import rthc_pkg::*;

  cls_t cls_in;
  cls_t cls_out;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;

  // Classify the pixel as it arrives.
  rthc_front u_front (
    .pixel (pixel),
    .cls   (cls_in)
  );

  // Queue between the front end and the divide pipeline.
  rthc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (pixel_valid),
    .din   (cls_in),
    .full  (queue_full),
    .pop   (queue_pop),
    .dout  (cls_out),
    .empty (queue_empty)
  );

  assign pixel_stall = queue_full;

  // Divide pipeline and result register.
  rthc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cls_valid    (!queue_empty),
    .cls          (cls_out),
    .pop          (queue_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
